/* src/iqsr_pkg.sv */
// Shared types and constants for the binary128 square root unit.
// No dependencies.
package iqsr_pkg;
  localparam int Prec     = 113;
  localparam int ExpW     = 15;
  localparam int FracBits = Prec - 1;
  localparam int EncW     = Prec + ExpW;
  localparam int RemW     = Prec + 4;
  localparam int IterW    = 7;
  localparam int Iters    = Prec + 1;
  localparam logic [ExpW-1:0] ExpOnes = '1;
  localparam logic [ExpW-1:0] ExpBias = {1'b0, {(ExpW-1){1'b1}}};

  typedef enum logic [2:0] {
    RM_RNE = 3'd0, RM_RUP = 3'd1, RM_RDN = 3'd2, RM_RTZ = 3'd3, RM_RMM = 3'd4
  } rmode_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic step;
    logic fin;
  } iqsr_cmd_t;

  typedef struct packed {
    logic special;
    logic normed;
    logic last;
  } iqsr_sts_t;
endpackage

/* src/ieee_quad_square_root_unit.sv */
// Binary128 square root, one bit of root per cycle.
// Subnormal operands are normalized first (one normalize shift per leading zero);
// specials skip normalization and the root loop.
// One transaction at a time; the next is taken after the result is taken.
// Reset (rst, synchronous) returns the sequencer to idle.
module ieee_quad_square_root_unit
  import iqsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] operand_high,
  input  logic [63:0] operand_low,
  input  logic [2:0]  rounding_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] root_high,
  output logic [63:0] root_low
);
  iqsr_cmd_t       cmd;
  iqsr_sts_t       sts;
  logic [EncW-1:0] result;

  iqsr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  iqsr_datapath u_dp (
    .clk, .operand_high, .operand_low, .rounding_mode, .cmd, .sts, .result
  );

  assign root_high = result[EncW-1:64];
  assign root_low  = result[63:0];

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(root_high) && $stable(root_low)))
    else $error("result dropped");
endmodule

/* src/iqsr_datapath.sv */
// Datapath: operand decode, normalize shifter, one-bit-per-cycle root, rounding.
// Depends on iqsr_pkg.
module iqsr_datapath
  import iqsr_pkg::*;
(
  input  logic             clk,
  input  logic [63:0]      operand_high,
  input  logic [63:0]      operand_low,
  input  logic [2:0]       rounding_mode,
  input  iqsr_cmd_t        cmd,
  output iqsr_sts_t        sts,
  output logic [EncW-1:0]  result
);
  logic [FracBits:0]   sig;
  logic [ExpW+1:0]     ee;
  logic                special;
  logic [EncW-1:0]     spec_res;
  logic [2:0]          mode;
  logic [Prec:0]       rad;
  logic [Prec:0]       q;
  logic [RemW-1:0]     rem;
  logic [IterW-1:0]    cnt;

  logic [EncW-1:0]     xin;
  logic [FracBits-1:0] fin_frac;
  logic [ExpW-1:0]     fin_exp;
  logic [RemW-1:0]     rem_sh, trial, rem_sub;
  logic                ge;
  logic                rnd, sticky, up;
  logic [Prec:0]       qr;
  logic [ExpW-1:0]     rexp;
  logic [ExpW+1:0]     half;

  assign xin      = {operand_high, operand_low};
  assign fin_frac = xin[FracBits-1:0];
  assign fin_exp  = xin[EncW-2:FracBits];

  assign rem_sh  = {rem[RemW-3:0], rad[Prec:Prec-1]};
  assign trial   = {{(RemW-Prec-3){1'b0}}, q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= rounding_mode;
      cnt  <= '0;
      q    <= '0;
      rem  <= '0;
      if ((fin_exp == ExpOnes && fin_frac != '0) || (fin_exp == '0 && fin_frac == '0)
          || (!xin[EncW-1] && fin_exp == ExpOnes)) begin
        special  <= 1'b1;
        spec_res <= xin;
      end else if (xin[EncW-1]) begin
        special  <= 1'b1;
        spec_res <= {1'b0, ExpOnes, 1'b1, {(FracBits-1){1'b0}}};
      end else begin
        special <= 1'b0;
      end
      if (fin_exp == '0) begin
        sig <= {1'b0, fin_frac};
        ee  <= (ExpW+2)'(1) + (ExpW+2)'(ExpBias) + (ExpW+2)'(2 * Prec);
      end else begin
        sig <= {1'b1, fin_frac};
        ee  <= (ExpW+2)'(fin_exp) + (ExpW+2)'(ExpBias) + (ExpW+2)'(2 * Prec);
      end
    end else if (cmd.norm) begin
      // shift one place per cycle until the hidden bit is set
      if (!sig[FracBits]) begin
        sig <= {sig[FracBits-1:0], 1'b0};
        ee  <= ee - 1'b1;
      end else begin
        rad <= ee[0] ? {sig, 1'b0} : {1'b0, sig};
      end
    end else if (cmd.step) begin
      // radicand pairs feed in while the padding zeros are not yet reached
      rad <= {rad[Prec-2:0], 2'b00};
      cnt <= cnt + 1'b1;
      if (ge) begin
        rem <= rem_sub;
        q   <= {q[Prec-1:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[Prec-1:0], 1'b0};
      end
    end else if (cmd.fin) begin
      if (special) result <= spec_res;
      else         result <= {1'b0, rexp, qr[FracBits-1:0]};
    end
  end

  // final rounding, registered into result
  always_comb begin
    rnd    = q[0];
    sticky = rem != '0;
    unique case (mode)
      RM_RUP:         up = rnd | sticky;
      RM_RDN, RM_RTZ: up = 1'b0;
      RM_RMM:         up = rnd;
      default:        up = rnd & (sticky | q[1]);
    endcase
    half = (ee >> 1) - (ExpW+2)'(Prec);
    rexp = half[ExpW-1:0];
    qr   = {1'b0, q[Prec:1]} + {{Prec{1'b0}}, up};
    if (qr[Prec]) begin
      qr   = qr >> 1;
      rexp = rexp + 1'b1;
    end
  end

  assign sts.special = special;
  assign sts.normed  = sig[FracBits];
  assign sts.last    = cnt == IterW'(Iters - 1);
endmodule

/* src/iqsr_ctrl.sv */
// Sequencer for the square root datapath: load, normalize, iterate, round.
// Depends on iqsr_pkg.
module iqsr_ctrl
  import iqsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output iqsr_cmd_t cmd,
  input  iqsr_sts_t sts
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_NORM, S_ITER, S_FIN, S_OUT} state_t;
  state_t state;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd      = '0;
    cmd.load = state == S_IDLE && in_valid;
    cmd.norm = state == S_NORM;
    cmd.step = state == S_ITER;
    cmd.fin  = state == S_FIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DEC;
        S_DEC:  state <= sts.special ? S_FIN : S_NORM;
        S_NORM: if (sts.normed) state <= S_ITER;
        S_ITER: if (sts.last) state <= S_FIN;
        S_FIN:  state <= S_OUT;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* verif/ieee_quad_square_root_unit_test.sv */
// Testbench for the binary128 square root unit: directed and random operands,
// checked against an in-bench root predictor. Depends on iqsr_pkg and the DUT.
`timescale 1ns / 100ps

module ieee_quad_square_root_unit_test;
  import iqsr_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] operand_high;
  logic [63:0] operand_low;
  logic [2:0]  rounding_mode;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] root_high;
  logic [63:0] root_low;

  logic [127:0] expected_roots[$];
  int           mismatches;
  bit           idling;

  ieee_quad_square_root_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operand_high(operand_high), .operand_low(operand_low),
    .rounding_mode(rounding_mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .root_high(root_high), .root_low(root_low)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Correctly rounded square root of one encoding.
  function automatic logic [127:0] predict_root(logic [127:0] x, logic [2:0] mode);
    logic [FracBits-1:0] frac;
    logic [ExpW-1:0]     ef;
    logic [127:0]        sig, rad, q, rem, trial;
    int                  ee, rexp, hi_idx, lo_idx;
    logic [1:0]          pair;
    logic                rnd, sticky, up;
    frac = x[FracBits-1:0];
    ef   = x[EncW-2:FracBits];
    if ((ef == ExpOnes && frac != '0) || (ef == '0 && frac == '0))
      return x;
    if (x[EncW-1])
      return {1'b0, ExpOnes, 1'b1, {(FracBits-1){1'b0}}};
    if (ef == ExpOnes)
      return x;
    sig = 128'(frac);
    if (ef == '0) begin
      ee = 1 + int'(ExpBias) + 2 * Prec;
      while (!sig[FracBits]) begin
        sig = sig << 1;
        ee--;
      end
    end else begin
      ee = int'(ef) + int'(ExpBias) + 2 * Prec;
      sig[FracBits] = 1'b1;
    end
    rad  = sig << (ee & 1);
    rexp = (ee >> 1) - Prec;
    q    = '0;
    rem  = '0;
    for (int j = Prec; j >= 0; j--) begin
      hi_idx = 2 * j + 1;
      lo_idx = 2 * j;
      pair   = '0;
      if (hi_idx >= Prec + 1) pair[1] = rad[hi_idx - (Prec + 1)];
      if (lo_idx >= Prec + 1) pair[0] = rad[lo_idx - (Prec + 1)];
      rem   = (rem << 2) | 128'(pair);
      trial = (q << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        q   = (q << 1) | 128'd1;
      end else begin
        q = q << 1;
      end
    end
    rnd    = q[0];
    q      = q >> 1;
    sticky = (rem != '0);
    case (mode)
      RM_RUP:         up = rnd | sticky;
      RM_RDN, RM_RTZ: up = 1'b0;
      RM_RMM:         up = rnd;
      default:        up = rnd & (sticky | q[0]);
    endcase
    if (up) begin
      q = q + 128'd1;
      if (q[Prec]) begin
        q = q >> 1;
        rexp++;
      end
    end
    return {1'b0, ExpW'(rexp), q[FracBits-1:0]};
  endfunction

  task automatic send_operand(logic [127:0] x, logic [2:0] mode);
    if (idling && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 19)) @(negedge clk);
    in_valid      = 1'b1;
    operand_high  = x[127:64];
    operand_low   = x[63:0];
    rounding_mode = mode;
    do @(posedge clk); while (!in_ready);
    expected_roots.push_back(predict_root(x, mode));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Drop out_ready in random bursts while idling is on.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected root transaction %h_%h", root_high, root_low);
        mismatches++;
      end else begin
        want = expected_roots.pop_front();
        if (root_high !== want[127:64]) begin
          $error("root_high expected %h actual %h", want[127:64], root_high);
          mismatches++;
        end
        if (root_low !== want[63:0]) begin
          $error("root_low expected %h actual %h", want[63:0], root_low);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [127:0] pack_quad(logic sign, logic [ExpW-1:0] ef,
                                             logic [FracBits-1:0] frac);
    return {sign, ef, frac};
  endfunction

  function automatic logic [127:0] random_bits();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_specials();
    send_operand(pack_quad(1'b0, ExpOnes, {1'b1, 111'd5}), RM_RNE);   // quiet NaN
    send_operand(pack_quad(1'b1, ExpOnes, 112'd1), RM_RUP);           // signalling NaN
    send_operand(pack_quad(1'b0, '0, '0), RM_RDN);                    // +0
    send_operand(pack_quad(1'b1, '0, '0), RM_RTZ);                    // -0
    send_operand(pack_quad(1'b0, ExpOnes, '0), RM_RMM);               // +inf
    send_operand(pack_quad(1'b1, ExpOnes, '0), RM_RNE);               // -inf
    send_operand(pack_quad(1'b1, ExpBias, '0), RM_RNE);               // -1.0
    send_operand(pack_quad(1'b1, '0, 112'd3), RM_RUP);                // negative subnormal
  endtask

  task automatic test_extremes();
    send_operand(pack_quad(1'b0, ExpW'(ExpOnes - 1), '1), RM_RUP);    // largest normal
    send_operand(pack_quad(1'b0, 15'd1, '0), RM_RNE);                 // smallest normal
    send_operand(pack_quad(1'b0, '0, 112'd1), RM_RNE);                // smallest subnormal
    send_operand(pack_quad(1'b0, '0, '1), RM_RMM);                    // largest subnormal
    send_operand(pack_quad(1'b0, ExpBias, '0), RM_RNE);               // 1.0
    send_operand(pack_quad(1'b0, ExpW'(ExpBias + 2), '0), RM_RDN);    // 4.0, exact
    send_operand(pack_quad(1'b0, ExpW'(ExpBias + 1), '1), RM_RUP);    // just under 4.0
  endtask

  task automatic test_rounding_modes();
    // sqrt(2) is inexact; mode codes above nearest-away fall back to nearest even
    for (int m = 0; m < 8; m++)
      send_operand(pack_quad(1'b0, ExpW'(ExpBias + 1), '0), 3'(m));
  endtask

  task automatic test_random(int count);
    logic [127:0] x;
    int           pick;
    for (int i = 0; i < count; i++) begin
      idling = (i < count - 200);
      x      = random_bits();
      pick   = $urandom_range(0, 99);
      if (pick < 5) begin
        // subnormal with a random number of leading zeros
        x[126:112] = '0;
        x[111:0]   = x[111:0] >> $urandom_range(0, 111);
        if (x[111:0] == '0) x[0] = 1'b1;
      end else if (pick < 12) begin
        x[126:112] = ExpOnes;
      end else if (pick < 15) begin
        x[126:0] = '0;
      end else begin
        if (x[126:112] == '0 || x[126:112] == ExpOnes) x[126:112] = ExpBias;
        if (pick < 25) x[127] = 1'b1;
        else if (pick < 60) x[127] = 1'b0;
      end
      send_operand(x, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    mismatches    = 0;
    idling        = 1'b1;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operand_high  = '0;
    operand_low   = '0;
    rounding_mode = RM_RNE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_specials();
    test_extremes();
    test_rounding_modes();
    test_random(2000);
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
